@@ rtl/aescbc_pkg.sv @@
// ----------------------------------------------------------------------------
// aescbc_pkg
// types, constants and round functions shared by the cbc cipher unit
// ----------------------------------------------------------------------------
package aescbc_pkg;

    localparam int ROUNDS     = 10;
    localparam int RK_WORDS   = 2 * (ROUNDS + 1);
    localparam int RK_AW      = $clog2(RK_WORDS);
    localparam int RND_W      = $clog2(ROUNDS + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic        restart_chain;
    } block_in_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } block_out_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[x];
    endfunction

    function automatic logic [7:0] rsbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the block sits at bits 127-8i .. 120-8i
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*c+r] = b[4*((c+r)%4)+r];
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (!last)
            begin
                t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
        return o;
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] x, input logic [3:0] y);
        logic [7:0] x2, x4, x8;
        x2 = xtime(x); x4 = xtime(x2); x8 = xtime(x4);
        return (y[0] ? x : 8'h00) ^ (y[1] ? x2 : 8'h00) ^ (y[2] ? x4 : 8'h00)
             ^ (y[3] ? x8 : 8'h00);
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
        begin
            a0 = s[127-32*c -: 8]; a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8]; a3 = s[103-32*c -: 8];
            o[127-32*c -: 8] = gmul(a0,4'he)^gmul(a1,4'hb)^gmul(a2,4'hd)^gmul(a3,4'h9);
            o[119-32*c -: 8] = gmul(a0,4'h9)^gmul(a1,4'he)^gmul(a2,4'hb)^gmul(a3,4'hd);
            o[111-32*c -: 8] = gmul(a0,4'hd)^gmul(a1,4'h9)^gmul(a2,4'he)^gmul(a3,4'hb);
            o[103-32*c -: 8] = gmul(a0,4'hb)^gmul(a1,4'hd)^gmul(a2,4'h9)^gmul(a3,4'he);
        end
        return o;
    endfunction

    // inverse shift rows then inverse sub bytes
    function automatic logic [127:0] dec_sub_shift(input logic [127:0] s);
        logic [7:0] t [16];
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*c+r] = rsbox(s[127-8*(4*((c-r+4)%4)+r) -: 8]);
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
        return o;
    endfunction

    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

@@ rtl/aescbc_stream_if.sv @@
// ----------------------------------------------------------------------------
// aescbc_stream_if
// valid/ready channel carrying a payload word
// ----------------------------------------------------------------------------
interface aescbc_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/aes128_cbc_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// aes128_cbc_cipher_unit
// AES-128 CBC encrypt/decrypt, one block at a time
// ----------------------------------------------------------------------------
// One 128-bit block is processed at a time; after acceptance a block passes
// through a load state with round key 0, or 10 when decrypting, on the
// round-key memory read port, ten rounds in the round state, each round key
// read from the round-key memory in the state before its round, and a done
// state that loads the output register. The next block is accepted in the
// cycle after the output register is loaded; a result word that has not
// been taken only holds the following block in its last cycle until the
// receiver takes it. After reset or a key write, the first block first runs
// the key expansion, writing one round key (two 64-bit entries, one each in
// two banks) per cycle. Chaining is kept in a two-entry chain memory, read
// in the load cycle when encrypting and in the done state when decrypting.
module aes128_cbc_cipher_unit
    import aescbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    aescbc_stream_if.sink         in_ch,
    aescbc_stream_if.source       out_ch
);

    logic [63:0]       key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic              direction_reg;
    logic              stale_reg;
    state_t            state_reg, state_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [127:0]      st_reg, st_next;
    logic [127:0]      kexp_reg, kexp_next;
    logic [7:0]        rc_reg, rc_next;
    logic [127:0]      din_reg;
    logic              restart_reg;
    logic [127:0]      res_reg;
    logic              res_valid_reg;

    // round-key memory: two banks, high and low halves of each round key
    logic [63:0]       rk_hi_mem [ROUNDS+1];
    logic [63:0]       rk_lo_mem [ROUNDS+1];
    logic [63:0]       rk_hi_q, rk_lo_q;
    logic              rk_we;
    logic [RND_W-1:0]  rk_waddr, rk_raddr;

    // chain memory, reset zero through a written flag
    logic [63:0]       ch_mem [2];
    logic [63:0]       ch_hi_q, ch_lo_q;
    logic              ch_written_reg;
    logic              ch_we;
    logic [127:0]      ch_wdata;

    logic              accept;
    logic              done_go;
    logic [127:0]      rk, chain, kround, dround, dsr;

    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = res_valid_reg;
    assign out_ch.data  = res_reg;
    // last cycle of a block ends once the output register is free
    assign done_go      = (state_reg == ST_DONE) && (!res_valid_reg || out_ch.ready);
    assign rk           = {rk_hi_q, rk_lo_q};
    assign chain        = restart_reg ? {iv_high_reg, iv_low_reg}
                        : ch_written_reg ? {ch_hi_q, ch_lo_q} : 128'd0;
    assign kround       = enc_round(st_reg, rnd_reg == RND_W'(ROUNDS));
    assign dsr          = dec_sub_shift(st_reg);
    assign dround       = dsr ^ rk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            iv_high_reg   <= '0;
            iv_low_reg    <= '0;
            direction_reg <= 1'b0;
            stale_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KEY_HIGH:  key_high_reg  <= cfg_data;
                    REG_KEY_LOW:   key_low_reg   <= cfg_data;
                    REG_IV_HIGH:   iv_high_reg   <= cfg_data;
                    REG_IV_LOW:    iv_low_reg    <= cfg_data;
                    REG_DIRECTION: direction_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW))
                stale_reg <= 1'b1;
            else if (state_reg == ST_EXPAND && rnd_reg == RND_W'(ROUNDS))
                stale_reg <= 1'b0;
        end
    end

    // the last expansion write is forwarded to a read of the same entry
    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_hi_mem[rk_waddr] <= kexp_reg[127:64];
            rk_lo_mem[rk_waddr] <= kexp_reg[63:0];
        end
        rk_hi_q <= (rk_we && rk_waddr == rk_raddr) ? kexp_reg[127:64] : rk_hi_mem[rk_raddr];
        rk_lo_q <= (rk_we && rk_waddr == rk_raddr) ? kexp_reg[63:0] : rk_lo_mem[rk_raddr];
        if (ch_we)
        begin
            ch_mem[0] <= ch_wdata[127:64];
            ch_mem[1] <= ch_wdata[63:0];
        end
        ch_hi_q <= ch_mem[0];
        ch_lo_q <= ch_mem[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rnd_reg        <= '0;
            res_valid_reg  <= 1'b0;
            ch_written_reg <= 1'b0;
            rc_reg         <= 8'h01;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            rc_reg    <= rc_next;
            if (ch_we)
                ch_written_reg <= 1'b1;
            if (done_go)
                res_valid_reg <= 1'b1;
            else if (out_ch.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        kexp_reg <= kexp_next;
        if (accept)
        begin
            din_reg     <= {in_ch.data.data_high, in_ch.data.data_low};
            restart_reg <= in_ch.data.restart_chain;
        end
        // decrypt output is the deciphered block xor the chain word
        if (done_go)
            res_reg <= direction_reg ? (st_reg ^ chain) : st_reg;
    end

    // decrypt walks round keys downward, encrypt upward
    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        st_next    = st_reg;
        kexp_next  = kexp_reg;
        rc_next    = rc_reg;
        rk_we      = 1'b0;
        rk_waddr   = rnd_reg;
        rk_raddr   = '0;
        ch_we      = 1'b0;
        ch_wdata   = st_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rnd_next  = '0;
                    kexp_next = {key_high_reg, key_low_reg};
                    rc_next   = 8'h01;
                    state_next = stale_reg ? ST_EXPAND : ST_LOAD;
                end
                rk_raddr = direction_reg ? RND_W'(ROUNDS) : '0;
            end
            ST_EXPAND:
            begin
                rk_we     = 1'b1;
                kexp_next = key_step(kexp_reg, rc_reg);
                rc_next   = xtime(rc_reg);
                rnd_next  = rnd_reg + 1'b1;
                rk_raddr  = direction_reg ? RND_W'(ROUNDS) : '0;
                if (rnd_reg == RND_W'(ROUNDS))
                begin
                    rnd_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // round key 0 (or 10) and chain word are on the read ports
                st_next    = direction_reg ? (din_reg ^ rk)
                                           : (din_reg ^ chain ^ rk);
                rnd_next   = RND_W'(1);
                rk_raddr   = direction_reg ? RND_W'(ROUNDS - 1) : RND_W'(1);
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                rnd_next = rnd_reg + 1'b1;
                rk_raddr = direction_reg ? RND_W'(ROUNDS - 1) - rnd_reg
                                         : rnd_reg + 1'b1;
                if (direction_reg)
                    st_next = (rnd_reg == RND_W'(ROUNDS)) ? dround : inv_mix(dround);
                else
                    st_next = kround ^ rk;
                if (rnd_reg == RND_W'(ROUNDS))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // chain word for decrypt is the input ciphertext
                if (done_go)
                begin
                    ch_we      = 1'b1;
                    ch_wdata   = direction_reg ? din_reg : st_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready)
        else $error("block accepted while busy");
    a_expand_before_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && $past(state_reg) == ST_EXPAND) |-> !stale_reg ||
        $past(cfg_we))
        else $error("keys still stale after expansion");
    a_done_to_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> out_ch.valid)
        else $error("result not presented");
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (rnd_reg != '0))
        else $error("round counter out of range");
`endif

endmodule

@@ sim/aes128_cbc_cipher_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aes128_cbc_cipher_unit_test
// drives directed and random blocks through the cbc cipher unit under
// several key, iv and direction settings, with random idling on both
// channels, and compares every result word with a cbc model of its own
// ----------------------------------------------------------------------------
module aes128_cbc_cipher_unit_test;
    import aescbc_pkg::*;

    typedef enum logic {ROW_CFG, ROW_BLOCK} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    index;
        logic [CFG_DATA_W-1:0]   value;
        block_in_t               word;
        bit                      typed;
        logic [127:0]            want;
    } stim_row_t;

    // indexes beyond the register list, which the block ignores
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int DIR_ENCRYPT = 0;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    aescbc_stream_if #(.payload_t(block_in_t))  in_ch ();
    aescbc_stream_if #(.payload_t(block_out_t)) out_ch ();

    aes128_cbc_cipher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // model state
    logic [7:0]   fwd_box [256];
    logic [7:0]   rev_box [256];
    logic [63:0]  m_key_high, m_key_low, m_iv_high, m_iv_low;
    logic         m_direction;
    logic [127:0] m_chain;
    logic [127:0] m_round_key [ROUNDS+1];
    bit           m_key_stale;

    logic [127:0] pending_blocks [$];
    int           errors;
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           hold_req;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (y[i])
                acc ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // s-box from the field inverse and the affine map
    task automatic build_boxes();
        logic [7:0] inv, b;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gf_mul(x[7:0], y[7:0]) == 8'h01)
                    inv = y[7:0];
            b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_box[x] = b;
            rev_box[b] = x[7:0];
        end
    endtask

    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input bit inv);
        for (int i = 0; i < 16; i++)
            s[127-8*i -: 8] = inv ? rev_box[s[127-8*i -: 8]] : fwd_box[s[127-8*i -: 8]];
        return s;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input bit inv);
        logic [127:0] t;
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                src = inv ? (c - r + 4) & 3 : (c + r) & 3;
                t[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
            end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input bit inv);
        logic [7:0] m [4];
        logic [7:0] a [4];
        logic [7:0] acc;
        logic [127:0] t;
        if (inv)
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
                a[k] = s[127-8*(4*c+k) -: 8];
            for (int r = 0; r < 4; r++)
            begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++)
                    acc ^= gf_mul(m[(4 - r + k) & 3], a[k]);
                t[127-8*(4*c+r) -: 8] = acc;
            end
        end
        return t;
    endfunction

    task automatic expand_round_keys();
        logic [127:0] k;
        logic [31:0]  t;
        logic [7:0]   rc;
        k = {m_key_high, m_key_low};
        rc = 8'h01;
        m_round_key[0] = k;
        for (int r = 1; r <= ROUNDS; r++)
        begin
            t = {fwd_box[k[23:16]] ^ rc, fwd_box[k[15:8]], fwd_box[k[7:0]], fwd_box[k[31:24]]};
            k[127:96] ^= t;
            k[95:64]  ^= k[127:96];
            k[63:32]  ^= k[95:64];
            k[31:0]   ^= k[63:32];
            m_round_key[r] = k;
            rc = gf_mul(rc, 8'h02);
        end
        m_key_stale = 1'b0;
    endtask

    function automatic logic [127:0] encipher(input logic [127:0] s);
        s ^= m_round_key[0];
        for (int r = 1; r <= ROUNDS; r++)
        begin
            s = shift_rows(sub_bytes(s, 1'b0), 1'b0);
            if (r != ROUNDS)
                s = mix_columns(s, 1'b0);
            s ^= m_round_key[r];
        end
        return s;
    endfunction

    function automatic logic [127:0] decipher(input logic [127:0] s);
        s ^= m_round_key[ROUNDS];
        for (int r = ROUNDS - 1; r >= 0; r--)
        begin
            s = sub_bytes(shift_rows(s, 1'b1), 1'b1);
            s ^= m_round_key[r];
            if (r != 0)
                s = mix_columns(s, 1'b1);
        end
        return s;
    endfunction

    task automatic cbc_predict(input block_in_t w, output logic [127:0] res);
        logic [127:0] chain;
        if (m_key_stale)
            expand_round_keys();
        chain = w.restart_chain ? {m_iv_high, m_iv_low} : m_chain;
        if (m_direction == DIR_ENCRYPT)
        begin
            res = encipher({w.data_high, w.data_low} ^ chain);
            m_chain = res;
        end
        else
        begin
            res = decipher({w.data_high, w.data_low}) ^ chain;
            m_chain = {w.data_high, w.data_low};
        end
    endtask

    task automatic model_reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        case (idx)
            REG_KEY_HIGH:  begin m_key_high = val; m_key_stale = 1'b1; end
            REG_KEY_LOW:   begin m_key_low = val; m_key_stale = 1'b1; end
            REG_IV_HIGH:   m_iv_high = val;
            REG_IV_LOW:    m_iv_low = val;
            REG_DIRECTION: m_direction = val[0];
            default: ;
        endcase
    endtask

    // waits with the input idle until every result is back and the block settles
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_we high; caller lowers it after the last write of a batch
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        model_reg_write(idx, val);
    endtask

    // leaves valid high so back-to-back words need no second assignment
    task automatic send_block(input block_in_t w, input bit typed, input logic [127:0] want);
        logic [127:0] res;
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge clk); while (!in_ch.ready);
        cbc_predict(w, res);
        if (typed && res !== want)
        begin
            $display("%0t: model disagrees with typed value: expected %h actual %h",
                     $time, want, res);
            errors++;
        end
        pending_blocks.push_back(typed ? want : res);
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic block_in_t random_block();
        block_in_t w;
        w.data_high = rand64();
        w.data_low  = rand64();
        case ($urandom_range(15))
            0: w.data_high = '0;
            1: w.data_high = '1;
            2: w.data_low  = '0;
            3: w.data_low  = '1;
            default: ;
        endcase
        w.restart_chain = ($urandom_range(7) == 0);
        return w;
    endfunction

    // receiver: checks results and stalls at random, or holds off on request
    initial
    begin
        block_out_t   got;
        logic [127:0] want;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                if (pending_blocks.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = pending_blocks.pop_front();
                    if (got.result_high !== want[127:64])
                    begin
                        $display("%0t: result_high expected %h actual %h",
                                 $time, want[127:64], got.result_high);
                        errors++;
                    end
                    if (got.result_low !== want[63:0])
                    begin
                        $display("%0t: result_low expected %h actual %h",
                                 $time, want[63:0], got.result_low);
                        errors++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("aes128_cbc_cipher_unit regression: fail");
        $finish;
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        int        phase_idle [4];
        int        phase_stall [4];
        errors = 0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        build_boxes();
        m_key_high = '0; m_key_low = '0; m_iv_high = '0; m_iv_low = '0;
        m_direction = 1'b0;
        m_chain = '0;
        m_key_stale = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        rows = '{};
        // zero key, zero chain after reset
        rows.push_back('{ROW_BLOCK, '0, '0, '{64'h0, 64'h0, 1'b0}, 1,
                         128'h66e94bd4ef8a2c3b884cfa59ca342b2e});
        rows.push_back('{ROW_CFG, REG_KEY_HIGH, 64'h0001020304050607, '0, 0, '0});
        rows.push_back('{ROW_CFG, REG_KEY_LOW, 64'h08090a0b0c0d0e0f, '0, 0, '0});
        rows.push_back('{ROW_CFG, REG_IV_HIGH, 64'h0, '0, 0, '0});
        rows.push_back('{ROW_CFG, REG_IV_LOW, 64'h0, '0, 0, '0});
        rows.push_back('{ROW_BLOCK, '0, '0,
                         '{64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1}, 1,
                         128'h69c4e0d86a7b0430d8cdb78070b4c55a});
        rows.push_back('{ROW_BLOCK, '0, '0, '{64'hffffffffffffffff, 64'hffffffffffffffff,
                         1'b0}, 0, '0});
        rows.push_back('{ROW_BLOCK, '0, '0, '{64'h0, 64'h0, 1'b0}, 0, '0});
        rows.push_back('{ROW_CFG, REG_DIRECTION, 64'h1, '0, 0, '0});
        rows.push_back('{ROW_CFG, REG_IV_HIGH, 64'hffffffffffffffff, '0, 0, '0});
        rows.push_back('{ROW_CFG, REG_IV_LOW, 64'hffffffffffffffff, '0, 0, '0});
        rows.push_back('{ROW_BLOCK, '0, '0,
                         '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1}, 1,
                         128'hffeeddccbbaa99887766554433221100});
        // a further decrypt block continues the chain
        rows.push_back('{ROW_BLOCK, '0, '0, '{64'h0, 64'hffffffffffffffff, 1'b0}, 0, '0});
        rows.push_back('{ROW_CFG, REG_SPARE_A, 64'hffffffffffffffff, '0, 0, '0});
        rows.push_back('{ROW_CFG, REG_SPARE_B, 64'h0123456789abcdef, '0, 0, '0});
        // only bit 0 of direction counts
        rows.push_back('{ROW_CFG, REG_DIRECTION, 64'hfffffffffffffffe, '0, 0, '0});
        rows.push_back('{ROW_BLOCK, '0, '0, '{64'hffffffffffffffff, 64'h0, 1'b0}, 0, '0});
        // key changed mid-chain
        rows.push_back('{ROW_CFG, REG_KEY_HIGH, 64'hffffffffffffffff, '0, 0, '0});
        rows.push_back('{ROW_BLOCK, '0, '0, '{64'h0123456789abcdef, 64'hfedcba9876543210,
                         1'b0}, 0, '0});
        rows.push_back('{ROW_CFG, REG_KEY_LOW, 64'hffffffffffffffff, '0, 0, '0});
        rows.push_back('{ROW_BLOCK, '0, '0, '{64'h0, 64'h0, 1'b1}, 0, '0});
        rows.push_back('{ROW_CFG, REG_DIRECTION, 64'h1, '0, 0, '0});
        rows.push_back('{ROW_BLOCK, '0, '0, '{64'h0, 64'h0, 1'b0}, 0, '0});
        rows.push_back('{ROW_BLOCK, '0, '0, '{64'hffffffffffffffff, 64'hffffffffffffffff,
                         1'b1}, 0, '0});

        foreach (rows[i])
        begin
            row = rows[i];
            if (row.kind == ROW_CFG)
            begin
                drain();
                reg_write(row.index, row.value);
                cfg_we <= 1'b0;
            end
            else
                send_block(row.word, row.typed, row.want);
        end

        // random phases: none, sender idle, receiver stall, both
        phase_idle  = '{0, 77, 0, 23};
        phase_stall = '{0, 0, 77, 23};
        for (int p = 0; p < 6; p++)
        begin
            drain();
            if (p == 5)
            begin
                reg_write(REG_KEY_HIGH, '0);
                reg_write(REG_KEY_LOW, '0);
                reg_write(REG_IV_HIGH, '1);
                reg_write(REG_IV_LOW, '0);
            end
            else
            begin
                reg_write(REG_KEY_HIGH, rand64());
                reg_write(REG_KEY_LOW, rand64());
                reg_write(REG_IV_HIGH, rand64());
                reg_write(REG_IV_LOW, rand64());
            end
            reg_write(REG_DIRECTION, {63'h0, p[0]});
            cfg_we <= 1'b0;
            send_idle_pct  = phase_idle[p % 4];
            recv_stall_pct = phase_stall[p % 4];
            // long receiver hold while words keep coming
            if (p == 0)
                hold_req = 1'b1;
            for (int n = 0; n < 75; n++)
            begin
                send_block(random_block(), 0, '0);
                sender_gap();
            end
        end

        drain();
        if (errors == 0)
            $display("aes128_cbc_cipher_unit regression: pass");
        else
            $display("aes128_cbc_cipher_unit regression: fail");
        $finish;
    end

endmodule

@@ aes128_cbc_cipher_unit.f @@
rtl/aescbc_pkg.sv
rtl/aescbc_stream_if.sv
rtl/aes128_cbc_cipher_unit.sv
sim/aes128_cbc_cipher_unit_test.sv
